/* rtl/bba_pkg.sv */
// Bitmap block allocator: shared constants, codes, states and unit structs.
// No dependencies; the interfaces, the word unit, the top and the bench import this package.
`default_nettype none
package bba_pkg;
  localparam int NUM_BLOCKS = 16384;
  localparam int BLOCK_SIZE = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = $clog2(MAP_WORDS);
  localparam int CNT_W      = 15;
  localparam int ADDR_W     = 32;
  localparam int FIRST_W    = 14;
  localparam int FRAME_W    = ADDR_W - $clog2(BLOCK_SIZE);
  localparam int POP_W      = $clog2(WORD_BITS + 1);
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [2:0] {
    REQ_INIT      = 3'd0,
    REQ_ALLOC     = 3'd1,
    REQ_FREE      = 3'd2,
    REQ_MARK_FREE = 3'd3,
    REQ_MARK_USED = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2,
    ST_ZERO     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL = 1'b0,
    CFG_BASE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SRD, S_SEV, S_MRD, S_MEV, S_DONE
  } state_t;

  typedef struct packed {
    logic               set_used;
    logic [CNT_W-1:0]   span_lo;
    logic [CNT_W-1:0]   span_hi;
    logic [CNT_W-1:0]   need;
    logic [CNT_W-1:0]   carry;
    logic [CNT_W-1:0]   total;
    logic [WADDR_W-1:0] word_idx;
  } wu_ctrl_t;

  typedef struct packed {
    logic                 hit;
    logic [CNT_W-1:0]     start;
    logic [CNT_W-1:0]     run_out;
    logic [WORD_BITS-1:0] new_word;
    logic [POP_W-1:0]     flips;
  } wu_res_t;
endpackage
`default_nettype wire

/* rtl/bba_in_if.sv */
// Request channel: valid/ready plus request payload.
// Depends on bba_pkg.
`default_nettype none
interface bba_in_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [CNT_W-1:0]  block_count;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] region_bytes;
  modport source (output valid, req_type, block_count, address, region_bytes, input ready);
  modport sink   (input valid, req_type, block_count, address, region_bytes, output ready);
endinterface
`default_nettype wire

/* rtl/bba_out_if.sv */
// Result channel: valid/ready plus result payload.
// Depends on bba_pkg.
`default_nettype none
interface bba_out_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  alloc_address;
  logic [FIRST_W-1:0] first_block;
  logic [CNT_W-1:0]   used_count;
  logic [CNT_W-1:0]   free_count;
  modport source (output valid, status, alloc_address, first_block, used_count, free_count,
                  input ready);
  modport sink   (input valid, status, alloc_address, first_block, used_count, free_count,
                  output ready);
endinterface
`default_nettype wire

/* rtl/bba_cfg_if.sv */
// Configuration write channel: valid/ready, register index and data.
// Depends on bba_pkg.
`default_nettype none
interface bba_cfg_if import bba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [ADDR_W-1:0]    data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* rtl/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/bba_word_unit.sv */
// Shared word unit: first-fit run search and span mark over one map word.
// Depends on bba_pkg.
`default_nettype none
module bba_word_unit import bba_pkg::*; (
  input  wire logic [WORD_BITS-1:0] rd_word,
  input  wire wu_ctrl_t             ctrl,
  output      wu_res_t              res
);
  logic [CNT_W-1:0]     gidx [WORD_BITS];
  logic [CNT_W-1:0]     run  [WORD_BITS];
  logic [WORD_BITS-1:0] busy;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] hitv;

  // per-bit global index, span mask, and "not usable" (used or past total)
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      gidx[i] = CNT_W'({ctrl.word_idx, BIT_W'(i)});
      mask[i] = (gidx[i] >= ctrl.span_lo) && (gidx[i] < ctrl.span_hi);
      busy[i] = rd_word[i] || (gidx[i] >= ctrl.total);
    end
  end

  // free run ending at bit i: distance to nearest busy bit at or below, else carry-in
  always_comb begin
    logic             seen;
    logic [BIT_W-1:0] last;
    for (int i = 0; i < WORD_BITS; i++) begin
      seen = 1'b0;
      last = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j <= i && busy[j]) begin
          seen = 1'b1;
          last = BIT_W'(j);
        end
      end
      run[i]  = seen ? (CNT_W'(i) - CNT_W'(last))
                     : (ctrl.carry + CNT_W'(i) + CNT_W'(1));
      hitv[i] = (run[i] >= ctrl.need);
    end
  end

  always_comb begin
    logic [POP_W-1:0] cnt;
    res.hit   = 1'b0;
    res.start = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hitv[i]) begin
        res.hit   = 1'b1;
        res.start = gidx[i] + CNT_W'(1) - ctrl.need;
      end
    end
    res.run_out  = run[WORD_BITS-1];
    res.new_word = ctrl.set_used ? (rd_word | mask) : (rd_word & ~mask);
    cnt = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      cnt = cnt + POP_W'(mask[i] && (ctrl.set_used ? !rd_word[i] : rd_word[i]));
    end
    res.flips = cnt;
  end
endmodule
`default_nettype wire

/* rtl/bitmap_block_allocator_top.sv */
// Bitmap block allocator, first-fit. A request passes S_CHECK and S_DONE plus the map work:
// initialise sweeps all 512 map words (one a cycle); allocate reads and checks each word
// up to the hit, then reads and rewrites each touched word; free/region mark likewise.
// One request at a time; the map RAM's single read and write port sets the pace.
// Reset (synchronous, rst_n low) restores state, used count and config, then a fill pass
// over all 512 map words sets every map bit before the first request transfer is taken.
`default_nettype none
module bitmap_block_allocator_top import bba_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  bba_in_if.sink   in_ch,
  bba_out_if.source out_ch,
  bba_cfg_if.sink  cfg_ch
);
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    total_r;
  logic [ADDR_W-1:0]   pool_r;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [2:0]          req_r;
  logic [CNT_W-1:0]    n_r;
  logic [ADDR_W-1:0]   addr_r, rb_r;
  logic [WADDR_W-1:0]  w_r, w_nxt;
  logic                from_req_r, from_req_nxt;
  status_t             status_r, status_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, carry_r, carry_nxt;
  logic                set_r, set_nxt;
  logic [FIRST_W-1:0]  first_r, first_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic [ADDR_W-1:0]   out_aaddr_r;
  logic [FIRST_W-1:0]  out_first_r;
  logic [CNT_W-1:0]    out_used_r, out_free_r;

  logic [CNT_W-1:0]    t_eff, avail, hi_m1, t_m1;
  logic [ADDR_W-1:0]   off;
  logic [FRAME_W-1:0]  fr_free, fr_reg, cnt_reg;
  logic [FRAME_W:0]    end_free, end_reg;
  logic                ram_we;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  wu_ctrl_t            wu_ctrl;
  wu_res_t             wu_res;

  // effective block count, saturated to the map size
  assign t_eff = (total_r > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : total_r;
  assign avail = (used_r >= t_eff) ? '0 : (t_eff - used_r);
  assign hi_m1 = hi_r - CNT_W'(1);
  assign t_m1  = t_eff - CNT_W'(1);

  // span checks: free is relative to the pool base, regions are absolute
  assign off      = addr_r - pool_r;
  assign fr_free  = FRAME_W'(off / BLOCK_SIZE);
  assign fr_reg   = FRAME_W'(addr_r / BLOCK_SIZE);
  assign cnt_reg  = FRAME_W'(rb_r / BLOCK_SIZE);
  assign end_free = (FRAME_W+1)'(fr_free) + (FRAME_W+1)'(n_r);
  assign end_reg  = (FRAME_W+1)'(fr_reg) + (FRAME_W+1)'(cnt_reg);

  assign wu_ctrl.set_used = set_r;
  assign wu_ctrl.span_lo  = lo_r;
  assign wu_ctrl.span_hi  = hi_r;
  assign wu_ctrl.need     = n_r;
  assign wu_ctrl.carry    = carry_r;
  assign wu_ctrl.total    = t_eff;
  assign wu_ctrl.word_idx = w_r;

  bba_word_unit u_word (
    .rd_word (ram_rdata),
    .ctrl    (wu_ctrl),
    .res     (wu_res)
  );

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_MEV);
  assign ram_wdata = (state_r == S_CLEAR) ? '1 : wu_res.new_word;

  bba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_r),
    .wdata (ram_wdata),
    .raddr (w_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.alloc_address = out_aaddr_r;
  assign out_ch.first_block   = out_first_r;
  assign out_ch.used_count    = out_used_r;
  assign out_ch.free_count    = out_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      w_r         <= '0;
      from_req_r  <= 1'b0;
      used_r      <= CNT_W'(NUM_BLOCKS);
      total_r     <= CNT_W'(NUM_BLOCKS);
      pool_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      from_req_r  <= from_req_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.addr)
          CFG_TOTAL: total_r <= cfg_ch.data[CNT_W-1:0];
          CFG_BASE:  pool_r  <= cfg_ch.data;
          default:   ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    carry_r  <= carry_nxt;
    set_r    <= set_nxt;
    first_r  <= first_nxt;
    if (in_ch.valid && in_ch.ready) begin
      req_r  <= in_ch.req_type;
      n_r    <= in_ch.block_count;
      addr_r <= in_ch.address;
      rb_r   <= in_ch.region_bytes;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_status_r <= status_r;
      out_used_r   <= used_r;
      out_free_r   <= avail;
      if (status_r == ST_OK && req_r == REQ_ALLOC) begin
        out_first_r <= first_r;
        out_aaddr_r <= pool_r + ADDR_W'(ADDR_W'(first_r) * ADDR_W'(BLOCK_SIZE));
      end else begin
        out_first_r <= '0;
        out_aaddr_r <= '0;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    from_req_nxt  = from_req_r;
    used_nxt      = used_r;
    status_nxt    = status_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    carry_nxt     = carry_r;
    set_nxt       = set_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      S_CLEAR: begin
        w_nxt = w_r + WADDR_W'(1);
        if (w_r == WADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = from_req_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt = ST_OK;
        first_nxt  = '0;
        carry_nxt  = '0;
        state_nxt  = S_DONE;
        case (req_r)
          REQ_INIT: begin
            used_nxt     = t_eff;
            w_nxt        = '0;
            from_req_nxt = 1'b1;
            state_nxt    = S_CLEAR;
          end
          REQ_ALLOC: begin
            if (n_r == '0) begin
              status_nxt = ST_ZERO;
            end else if (avail < n_r) begin
              status_nxt = ST_NO_SPACE;
            end else begin
              w_nxt     = '0;
              state_nxt = S_SRD;
            end
          end
          REQ_FREE: begin
            if (n_r == '0) begin
              status_nxt = ST_ZERO;
            end else if (end_free > (FRAME_W+1)'(t_eff)) begin
              status_nxt = ST_RANGE;
            end else begin
              lo_nxt    = CNT_W'(fr_free);
              hi_nxt    = CNT_W'(end_free);
              set_nxt   = 1'b0;
              w_nxt     = fr_free[BIT_W +: WADDR_W];
              state_nxt = S_MRD;
            end
          end
          REQ_MARK_FREE, REQ_MARK_USED: begin
            if (cnt_reg == '0) begin
              status_nxt = ST_ZERO;
            end else if (end_reg > (FRAME_W+1)'(t_eff)) begin
              status_nxt = ST_RANGE;
            end else begin
              lo_nxt    = CNT_W'(fr_reg);
              hi_nxt    = CNT_W'(end_reg);
              set_nxt   = (req_r == REQ_MARK_USED);
              w_nxt     = fr_reg[BIT_W +: WADDR_W];
              state_nxt = S_MRD;
            end
          end
          default: status_nxt = ST_RANGE;
        endcase
      end
      S_SRD: state_nxt = S_SEV;
      S_SEV: begin
        if (wu_res.hit) begin
          lo_nxt    = wu_res.start;
          hi_nxt    = wu_res.start + n_r;
          first_nxt = wu_res.start[FIRST_W-1:0];
          set_nxt   = 1'b1;
          w_nxt     = wu_res.start[BIT_W +: WADDR_W];
          state_nxt = S_MRD;
        end else if (w_r == t_m1[BIT_W +: WADDR_W]) begin
          status_nxt = ST_NO_SPACE;
          state_nxt  = S_DONE;
        end else begin
          carry_nxt = wu_res.run_out;
          w_nxt     = w_r + WADDR_W'(1);
          state_nxt = S_SRD;
        end
      end
      S_MRD: state_nxt = S_MEV;
      S_MEV: begin
        if (set_r) begin
          used_nxt = used_r + CNT_W'(wu_res.flips);
        end else begin
          used_nxt = (used_r >= CNT_W'(wu_res.flips)) ? (used_r - CNT_W'(wu_res.flips)) : '0;
        end
        if (w_r == hi_m1[BIT_W +: WADDR_W]) begin
          state_nxt = S_DONE;
        end else begin
          w_nxt     = w_r + WADDR_W'(1);
          state_nxt = S_MRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          from_req_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // used count never exceeds the number of map bits
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(NUM_BLOCKS))
    else $error("used count above map size");

  // a failed request reports no run
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_aaddr_r == '0 && out_first_r == '0))
    else $error("failed request carries an address");

  // a found run lies wholly below the effective block count
  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEV && wu_res.hit) |=> (hi_r <= t_eff && state_r == S_MRD))
    else $error("allocated run past end of map");

  // marking never moves the used count on a request that was rejected
  a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && state_nxt == S_DONE) |=> $stable(used_r))
    else $error("used count changed on rejected request");
endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking bench for bitmap_block_allocator_top: a bit-level model of the used map
// predicts every result, and the checker compares each result transfer field by field.
// Depends on bba_pkg, the bba_in_if, bba_out_if and bba_cfg_if interfaces and bitmap_block_allocator_top.
`default_nettype none
module tb;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t          st;
    logic [31:0]      addr;
    logic [13:0]      first;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] free;
  } alloc_result_t;

  typedef struct {
    int unsigned first;
    int unsigned n;
  } run_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  bba_in_if  in_ch();
  bba_out_if out_ch();
  bba_cfg_if cfg_ch();

  bitmap_block_allocator_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Shadow copy of the block's state and registers.
  bit [NUM_BLOCKS-1:0] used_map;
  int unsigned         shadow_used;
  logic [CNT_W-1:0]    total_reg;
  logic [31:0]         base_reg;

  alloc_result_t pending_results[$];
  run_t          live_runs[$];       // allocated runs, used to build sensible frees
  int            errors = 0;
  int            status_seen[4];
  int            requests_sent = 0;
  bit            calm = 1'b0;        // no idling on either side in the final stretch
  bit            busy_cfg = 1'b0;

  function automatic int unsigned eff_total();
    return (total_reg > NUM_BLOCKS) ? NUM_BLOCKS : int'(total_reg);
  endfunction

  // Flip one bit; the count moves only when the bit really changes.
  function automatic void put_bit(int unsigned b, bit val);
    if (used_map[b] == val) return;
    used_map[b] = val;
    if (val) shadow_used++;
    else if (shadow_used > 0) shadow_used--;
  endfunction

  function automatic alloc_result_t predict_request(logic [2:0] rq, logic [CNT_W-1:0] n,
                                                    logic [31:0] a, logic [31:0] rb);
    alloc_result_t r;
    int unsigned   t, avail, run, start;
    longint unsigned frame, cnt;
    bit            found;
    t = eff_total();
    r.st = ST_OK; r.addr = '0; r.first = '0;
    case (rq)
      REQ_INIT: begin
        used_map = '1;
        shadow_used = t;
      end
      REQ_ALLOC: begin
        avail = (shadow_used >= t) ? 0 : t - shadow_used;
        if (n == 0) r.st = ST_ZERO;
        else if (avail < n) r.st = ST_NO_SPACE;
        else begin
          run = 0; start = 0; found = 1'b0;
          for (int unsigned b = 0; b < t && !found; b++) begin
            if (used_map[b]) run = 0;
            else begin
              if (run == 0) start = b;
              run++;
              if (run == n) found = 1'b1;
            end
          end
          if (!found) r.st = ST_NO_SPACE;
          else begin
            for (int unsigned i = 0; i < n; i++) put_bit(start + i, 1'b1);
            r.addr  = 32'(longint'(start) * BLOCK_SIZE + base_reg);
            r.first = 14'(start);
          end
        end
      end
      REQ_FREE: begin
        frame = longint'(32'(a - base_reg)) / BLOCK_SIZE;
        if (n == 0) r.st = ST_ZERO;
        else if (frame + n > t) r.st = ST_RANGE;
        else for (int unsigned i = 0; i < n; i++) put_bit(32'(frame) + i, 1'b0);
      end
      REQ_MARK_FREE, REQ_MARK_USED: begin
        frame = longint'(a) / BLOCK_SIZE;
        cnt   = longint'(rb) / BLOCK_SIZE;
        if (cnt == 0) r.st = ST_ZERO;
        else if (frame + cnt > t) r.st = ST_RANGE;
        else for (int unsigned i = 0; i < cnt; i++)
          put_bit(32'(frame) + i, rq == REQ_MARK_USED);
      end
      default: r.st = ST_RANGE;
    endcase
    r.used = CNT_W'(shadow_used);
    r.free = (shadow_used >= t) ? '0 : CNT_W'(t - shadow_used);
    return r;
  endfunction

  // Send one request; the prediction is made when the transfer happens.
  task automatic send_request(input logic [2:0] rq, input logic [CNT_W-1:0] n,
                              input logic [31:0] a, input logic [31:0] rb,
                              output alloc_result_t r);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.req_type = rq; in_ch.block_count = n; in_ch.address = a; in_ch.region_bytes = rb;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_request(rq, n, a, rb);
    pending_results.push_back(r);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic req(input logic [2:0] rq, input logic [CNT_W-1:0] n,
                     input logic [31:0] a, input logic [31:0] rb);
    alloc_result_t r;
    send_request(rq, n, a, rb, r);
  endtask

  // Drop valid, let every result come back, then give the block a few cycles more.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    drain();
    cfg_ch.addr = idx; cfg_ch.data = val; cfg_ch.valid = 1'b1;
    busy_cfg = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_TOTAL) total_reg = val[CNT_W-1:0];
    else base_reg = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    busy_cfg = 1'b0;
  endtask

  // ---------------------------------------------------------------------------------
  // Directed requests with the reset settings: whole map used, total 16384, base 0.
  // ---------------------------------------------------------------------------------
  task automatic test_directed();
    req(REQ_ALLOC, 1, 0, 0);                         // nothing free yet
    req(REQ_ALLOC, 0, 0, 0);                         // zero count
    req(REQ_FREE, 0, 0, 0);
    req(REQ_MARK_FREE, 5, 0, BLOCK_SIZE - 1);        // region under one block
    req(REQ_MARK_FREE, 0, 32'h0000_0abc, 64 * BLOCK_SIZE);
    req(REQ_MARK_USED, 0, 0, 30 * BLOCK_SIZE + 12'hfff);
    req(REQ_ALLOC, 5, 0, 0);                         // run crosses the word boundary at 32
    req(REQ_FREE, 1, 31 * BLOCK_SIZE, 0);
    req(REQ_FREE, 1, 33 * BLOCK_SIZE + 7, 0);
    req(REQ_MARK_USED, 0, 36 * BLOCK_SIZE, BLOCK_SIZE);
    req(REQ_ALLOC, 2, 0, 0);                         // isolated holes must be skipped
    req(REQ_FREE, 1, 31 * BLOCK_SIZE, 0);            // already free: count unchanged
    req(REQ_FREE, 2, (NUM_BLOCKS - 1) * BLOCK_SIZE, 0);
    req(REQ_MARK_FREE, 0, 32'hffff_f000, 32'hffff_ffff);
    req(REQ_MARK_USED, 0, 32'hffff_ffff, 32'hffff_ffff);
    req(REQ_ALLOC, CNT_W'(NUM_BLOCKS), 0, 0);        // more than is free
    req(REQ_ALLOC, '1, 0, 0);
    req(REQ_FREE, '1, 0, 0);
    req(3'(REQ_MARK_USED) + 3'd1, 1, 0, BLOCK_SIZE); // unknown request codes
    req(3'(REQ_MARK_USED) + 3'd2, 1, 0, BLOCK_SIZE);
    req(3'(REQ_MARK_USED) + 3'd3, '1, '1, '1);
    req(REQ_INIT, '1, '1, '1);
    req(REQ_ALLOC, 1, 0, 0);
  endtask

  // ---------------------------------------------------------------------------------
  // Register extremes: empty pool, saturating total, top base, count left stale.
  // ---------------------------------------------------------------------------------
  task automatic test_config_extremes();
    write_reg(CFG_TOTAL, 0);
    req(REQ_INIT, 0, 0, 0);
    req(REQ_ALLOC, 1, 0, 0);
    req(REQ_FREE, 1, 0, 0);
    req(REQ_MARK_FREE, 0, 0, BLOCK_SIZE);
    write_reg(CFG_TOTAL, 32'h7fff);                  // above the map size: saturates
    req(REQ_INIT, 0, 0, 0);
    req(REQ_MARK_FREE, 0, 0, 32'hffff_ffff);         // past the end
    req(REQ_MARK_FREE, 0, 0, NUM_BLOCKS * BLOCK_SIZE);
    req(REQ_ALLOC, CNT_W'(NUM_BLOCKS), 0, 0);        // takes the whole map
    write_reg(CFG_BASE, 32'hffff_ffff);
    req(REQ_FREE, 1, 32'hffff_fffe, 0);              // below base: wraps out of range
    req(REQ_FREE, 3, 32'h0000_0fff, 0);
    req(REQ_ALLOC, 2, 0, 0);                         // address wraps
    write_reg(CFG_TOTAL, 100);                       // used count now above total
    req(REQ_ALLOC, 1, 0, 0);
    req(REQ_FREE, 4, 32'hffff_ffff, 0);
    req(REQ_MARK_FREE, 0, 0, 100 * BLOCK_SIZE);
    req(REQ_INIT, 0, 0, 0);
    write_reg(CFG_TOTAL, NUM_BLOCKS);
    write_reg(CFG_BASE, 0);
  endtask

  // One random request, mostly well formed against the current map.
  task automatic random_request(input int unsigned t);
    alloc_result_t r;
    run_t          run;
    int unsigned   pick, blk, cnt, k;
    logic [2:0]    rq;
    logic [CNT_W-1:0] n;
    logic [31:0]   a, rb;
    pick = $urandom_range(0, 99);
    rq = REQ_INIT; n = CNT_W'($urandom); a = $urandom; rb = $urandom;
    blk = (t == 0) ? 0 : $urandom_range(0, t - 1);
    cnt = $urandom_range(1, 48);
    if (pick < 2) rq = REQ_INIT;
    else if (pick < 38) begin
      rq = REQ_ALLOC;
      n = ($urandom_range(0, 19) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 24));
    end else if (pick < 62) begin
      rq = REQ_FREE;
      if (live_runs.size() != 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[k];
        live_runs.delete(k);
        blk = run.first; cnt = run.n;
      end
      n = CNT_W'(cnt);
      a = base_reg + blk * BLOCK_SIZE + $urandom_range(0, BLOCK_SIZE - 1);
    end else if (pick < 87) begin
      rq = (pick < 77) ? REQ_MARK_FREE : REQ_MARK_USED;
      a  = blk * BLOCK_SIZE + $urandom_range(0, BLOCK_SIZE - 1);
      rb = cnt * BLOCK_SIZE + $urandom_range(0, BLOCK_SIZE - 1);
    end else if (pick < 92) begin
      rq = 3'($urandom_range(5, 7));                 // unknown codes
    end else begin
      rq = 3'($urandom_range(1, 4));                 // raw noise on every field
    end
    send_request(rq, n, a, rb, r);
    if (rq == REQ_INIT) live_runs.delete();
    if (rq == REQ_ALLOC && r.st == ST_OK) begin
      run.first = r.first; run.n = n;
      live_runs.push_back(run);
    end
  endtask

  task automatic random_phase(input logic [31:0] total, input logic [31:0] base,
                              input int items);
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_BASE, base);
    live_runs.delete();
    req(REQ_INIT, 0, 0, 0);
    req(REQ_MARK_FREE, 0, 0, eff_total() * BLOCK_SIZE);
    repeat (items) random_request(eff_total());
  endtask

  // ---------------------------------------------------------------------------------
  // Random traffic over several register settings; the last one runs with no idling.
  // ---------------------------------------------------------------------------------
  task automatic test_random();
    random_phase(64, $urandom, 200);
    random_phase(1000, 32'h8000_0000, 200);
    random_phase($urandom_range(1, 2048), $urandom, 200);
    random_phase(NUM_BLOCKS, $urandom, 60);
    random_phase(32, 32'hffff_ffff, 100);
    calm = 1'b1;
    random_phase(3000, $urandom, 240);
  endtask

  // Result side: random stalls on ready, then a field-by-field check of each transfer.
  int hold = 0;
  always @(negedge clk) begin
    if (hold > 0) begin
      hold <= hold - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      hold <= $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        status_seen[e.st]++;
        if (out_ch.status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, out_ch.status); errors++;
        end
        if (out_ch.alloc_address !== e.addr) begin
          $error("alloc_address: expected %h, got %h", e.addr, out_ch.alloc_address);
          errors++;
        end
        if (out_ch.first_block !== e.first) begin
          $error("first_block: expected %0d, got %0d", e.first, out_ch.first_block);
          errors++;
        end
        if (out_ch.used_count !== e.used) begin
          $error("used_count: expected %0d, got %0d", e.used, out_ch.used_count); errors++;
        end
        if (out_ch.free_count !== e.free) begin
          $error("free_count: expected %0d, got %0d", e.free, out_ch.free_count); errors++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no transfer anywhere ends the run.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || (pending_results.size() == 0 && !busy_cfg &&
        !in_ch.valid))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= 20000) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.req_type = REQ_INIT; in_ch.block_count = '0;
    in_ch.address = '0; in_ch.region_bytes = '0;
    cfg_ch.valid = 1'b0; cfg_ch.addr = CFG_TOTAL; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    total_reg = NUM_BLOCKS; base_reg = '0;
    used_map = '1; shadow_used = NUM_BLOCKS;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_config_extremes();
    test_random();
    drain();

    $display("%0d requests checked: %0d ok, %0d no space, %0d out of range, %0d zero count",
             requests_sent, status_seen[ST_OK], status_seen[ST_NO_SPACE],
             status_seen[ST_RANGE], status_seen[ST_ZERO]);
    $display("register settings covered empty, saturated and wrapped pools");
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
